>>> sv/tws_pkg.sv
// tick window statistics: shared types, widths and codes
// used by every module of the block, no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tws_pkg;

  localparam int PRICE_W        = 32;
  localparam int VOL_W          = 32;
  localparam int RES_W          = 32;
  localparam int FILL_OUT_W     = 9;
  localparam int WIN_W          = 9;
  localparam int SPAN_W         = 16;
  localparam int CMP_W          = 16;
  localparam int ENT_W          = 2 * PRICE_W + VOL_W;
  localparam int IN_DATA_W      = 96;
  localparam int OUT_DATA_W     = 144;
  localparam int CFG_AW         = 4;
  localparam int CFG_DW         = 32;
  localparam int DVS_W          = 64;
  localparam int Q_W            = 64;
  localparam int MUL_W          = 34;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int ALPHA_W        = 33;
  localparam int ALPHA_NB       = 34;
  localparam int RAD_W          = 64;
  localparam int ROOT_W         = 32;
  localparam int DEF_RING_DEPTH = 256;

  localparam logic [WIN_W-1:0]  CAP_RST  = 9'd256;
  localparam logic [WIN_W-1:0]  SMA_RST  = 9'd20;
  localparam logic [SPAN_W-1:0] SPAN_RST = 16'd20;
  localparam logic [WIN_W-1:0]  DEV_RST  = 9'd20;

  typedef enum logic [1:0] {
    REG_CAP  = 2'd0,
    REG_SMA  = 2'd1,
    REG_SPAN = 2'd2,
    REG_DEV  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ALPHA, S_ALPHA_W, S_RD, S_MX, S_MP, S_ME, S_DRAIN,
    S_SMA, S_SMA_W, S_DM, S_DEV, S_DEV_W, S_SQRT, S_SQRT_W,
    S_VW, S_VW_W, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    K_NONE, K_SQ, K_PV, K_EMA, K_D0, K_D32, K_D64,
    K_N0, K_N33, K_N64, K_MM
  } kind_t;

  typedef enum logic [2:0] {
    DM_M_S2LO, DM_M_S2MID, DM_M_S2HI, DM_LO_LO,
    DM_LO_HI, DM_HI_HI, DM_M_M1, DM_DRAIN
  } dm_step_t;

endpackage
`default_nettype wire

>>> sv/tick_window_statistics.sv
// tick_window_statistics: ring of ticks with SMA, EMA, deviation and VWAP
// depends on tws_pkg, tws_ring, tws_div, tws_isqrt
//
// in_ channel: one request per tick; in_tuser is the command (push or clear),
// in_tdata carries mid price, trade price and volume. out_ channel: one
// result per request with SMA, EMA, deviation, VWAP and fill count.
// cfg_ port: APB registers ring_capacity, sma_window, ema_span,
// deviation_window at 0x0, 0x4, 0x8, 0xc; write only while idle.
// one request at a time: in_tready is high only in idle. a request walks the
// stored ticks through one shared 34x34 multiplier in states MX, MP and ME per
// tick, and it uses up to four bit-serial divisions, the first (the EMA weight)
// before the walk, and a 32-step square root. a new request is taken in the
// cycle after the result loads.
// the result waits in an output register; a new request is taken while it
// waits, and a second result waits in the last state until out_tready.
// reset empties the ring and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module tick_window_statistics
  import tws_pkg::*;
#(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // mid, trade_price, trade_volume
  input  wire logic                  in_tuser,   // cmd
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // simple_average, exp_average,
                                                 // std_deviation, volume_weighted_price,
                                                 // fill_count
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_AW-1:0]     cfg_paddr,
  input  wire logic [CFG_DW-1:0]     cfg_pwdata,
  output logic      [CFG_DW-1:0]     cfg_prdata,
  output logic                       cfg_pready
);

  localparam int ADDR_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int S1_W      = PRICE_W + CNT_W;
  localparam int S2_W      = 2 * PRICE_W + CNT_W;
  localparam int PV_W      = PRICE_W + VOL_W + CNT_W;
  localparam int VS_W      = VOL_W + CNT_W;
  localparam int DVD_W     = 2 * PRICE_W + 2 * CNT_W;
  localparam int NB_W      = $clog2(DVD_W + 1);

  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0] idx);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(idx);
    if (s >= (CNT_W + 1)'(RING_DEPTH)) s = s - (CNT_W + 1)'(RING_DEPTH);
    return s[ADDR_W-1:0];
  endfunction

  state_t  state_r, state_nxt;
  kind_t   kind_r, kind_nxt;
  dm_step_t step_r;

  logic [WIN_W-1:0]  cap_r, sma_win_r, dev_win_r;
  logic [SPAN_W-1:0] span_r;
  logic [CNT_W-1:0]  fill_r, idx_r, sma_m, dev_m, sma_start, dev_start;
  logic [ADDR_W-1:0] oldest_r, raddr;
  logic [CMP_W-1:0]  cap_eff;
  logic              accept, full, cfg_wr, out_load, sma_in, dev_in;
  logic [ENT_W-1:0]  rd_data;
  logic [PRICE_W-1:0] x, p;
  logic [VOL_W-1:0]  v;

  logic [ALPHA_W-1:0] alpha_r;
  logic [PRICE_W-1:0] ema_r;
  logic [S1_W-1:0]   sma_sum_r, s1_r;
  logic [S2_W-1:0]   s2_r;
  logic [PV_W-1:0]   pv_r;
  logic [VS_W-1:0]   vol_r;
  logic [DVD_W-1:0]  dacc_r;
  logic [DVS_W-1:0]  mm_r;
  logic [Q_W-1:0]    dq_r;
  logic [RES_W-1:0]  sma_res_r, dev_res_r, vw_res_r, ema_out;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic              out_valid_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;

  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd;
  logic [NB_W-1:0]  div_nb;
  logic [DVS_W-1:0] div_dvs;
  logic [Q_W-1:0]   div_q;
  logic             sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RST;
      sma_win_r <= SMA_RST;
      span_r    <= SPAN_RST;
      dev_win_r <= DEV_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_paddr[3:2]))
        REG_CAP:  cap_r     <= cfg_pwdata[WIN_W-1:0];
        REG_SMA:  sma_win_r <= cfg_pwdata[WIN_W-1:0];
        REG_SPAN: span_r    <= cfg_pwdata[SPAN_W-1:0];
        REG_DEV:  dev_win_r <= cfg_pwdata[WIN_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[3:2]))
      REG_CAP:  cfg_prdata = CFG_DW'(cap_r);
      REG_SMA:  cfg_prdata = CFG_DW'(sma_win_r);
      REG_SPAN: cfg_prdata = CFG_DW'(span_r);
      REG_DEV:  cfg_prdata = CFG_DW'(dev_win_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // ring bookkeeping
  always_comb begin
    cap_eff = CMP_W'(cap_r);
    if (cap_eff == '0) cap_eff = CMP_W'(1);
    if (cap_eff > CMP_W'(RING_DEPTH)) cap_eff = CMP_W'(RING_DEPTH);
    full = CMP_W'(fill_r) >= cap_eff;
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      oldest_r <= '0;
    end else if (accept) begin
      if (cmd_t'(in_tuser) == CMD_CLEAR) begin
        fill_r   <= '0;
        oldest_r <= '0;
      end else if (full) begin
        oldest_r <= slot_of(oldest_r, CNT_W'(1));
      end else begin
        fill_r <= fill_r + CNT_W'(1);
      end
    end
  end

  tws_ring #(.DEPTH(RING_DEPTH), .AW(ADDR_W)) u_ring (
    .clk   (clk),
    .we    (accept && cmd_t'(in_tuser) == CMD_PUSH),
    .waddr (slot_of(oldest_r, fill_r)),
    .wdata (in_tdata[ENT_W-1:0]),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign x = rd_data[PRICE_W-1:0];
  assign p = rd_data[2*PRICE_W-1:PRICE_W];
  assign v = rd_data[ENT_W-1:2*PRICE_W];

  // window bounds
  always_comb begin
    sma_m     = (CMP_W'(sma_win_r) < CMP_W'(fill_r)) ? CNT_W'(sma_win_r) : fill_r;
    dev_m     = (CMP_W'(dev_win_r) < CMP_W'(fill_r)) ? CNT_W'(dev_win_r) : fill_r;
    sma_start = fill_r - sma_m;
    dev_start = fill_r - dev_m;
    sma_in    = idx_r >= sma_start;
    dev_in    = idx_r >= dev_start;
  end

  // shared units
  tws_div #(.DVD_W(DVD_W), .NB_W(NB_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .nbits    (div_nb),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  tws_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (dq_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (accept) state_nxt = S_ALPHA;
      S_ALPHA: begin
        if (fill_r == '0) state_nxt = S_OUT;
        else if (span_r == '0) state_nxt = S_RD;
        else state_nxt = S_ALPHA_W;
      end
      S_ALPHA_W: if (div_done) state_nxt = S_RD;
      S_RD:      state_nxt = S_MX;
      S_MX:      state_nxt = S_MP;
      S_MP:      state_nxt = S_ME;
      S_ME:      state_nxt = (idx_r + CNT_W'(1) == fill_r) ? S_DRAIN : S_MX;
      S_DRAIN:   state_nxt = S_SMA;
      S_SMA: begin
        if (sma_m != '0) state_nxt = S_SMA_W;
        else if (dev_m >= CNT_W'(2)) state_nxt = S_DM;
        else state_nxt = S_VW;
      end
      S_SMA_W: begin
        if (div_done) state_nxt = (dev_m >= CNT_W'(2)) ? S_DM : S_VW;
      end
      S_DM:      if (step_r == DM_DRAIN) state_nxt = S_DEV;
      S_DEV:     state_nxt = S_DEV_W;
      S_DEV_W:   if (div_done) state_nxt = S_SQRT;
      S_SQRT:    state_nxt = S_SQRT_W;
      S_SQRT_W:  if (sqrt_done) state_nxt = S_VW;
      S_VW:      state_nxt = (vol_r == '0) ? S_OUT : S_VW_W;
      S_VW_W:    if (div_done) state_nxt = S_OUT;
      S_OUT:     if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // controls
  always_comb begin
    in_tready  = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    kind_nxt   = K_NONE;
    raddr      = slot_of(oldest_r, idx_r);
    div_start  = 1'b0;
    div_dvd    = '0;
    div_nb     = '0;
    div_dvs    = '0;
    sqrt_start = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_ALPHA: begin
        div_start = (fill_r != '0) && (span_r != '0);
        div_dvd   = DVD_W'(1) << (DVD_W - 1);
        div_nb    = NB_W'(ALPHA_NB);
        div_dvs   = DVS_W'(span_r) + DVS_W'(1);
      end
      S_MX: begin
        mul_a    = MUL_W'(x);
        mul_b    = MUL_W'(x);
        kind_nxt = dev_in ? K_SQ : K_NONE;
      end
      S_MP: begin
        mul_a    = MUL_W'(p);
        mul_b    = MUL_W'(v);
        kind_nxt = K_PV;
      end
      S_ME: begin
        raddr = slot_of(oldest_r, idx_r + CNT_W'(1));
        if (idx_r != '0 && span_r != '0) begin
          mul_a    = MUL_W'(alpha_r);
          mul_b    = MUL_W'(x) - MUL_W'(ema_r);
          kind_nxt = K_EMA;
        end
      end
      S_SMA: begin
        div_start = sma_m != '0;
        div_dvd   = DVD_W'(sma_sum_r) << (DVD_W - S1_W);
        div_nb    = NB_W'(S1_W);
        div_dvs   = DVS_W'(sma_m);
      end
      S_DM: begin
        unique case (step_r)
          DM_M_S2LO: begin
            mul_a = MUL_W'(dev_m); mul_b = MUL_W'(s2_r[31:0]); kind_nxt = K_D0;
          end
          DM_M_S2MID: begin
            mul_a = MUL_W'(dev_m); mul_b = MUL_W'(s2_r[63:32]); kind_nxt = K_D32;
          end
          DM_M_S2HI: begin
            mul_a = MUL_W'(dev_m); mul_b = MUL_W'(s2_r[S2_W-1:64]); kind_nxt = K_D64;
          end
          DM_LO_LO: begin
            mul_a = MUL_W'(s1_r[31:0]); mul_b = MUL_W'(s1_r[31:0]); kind_nxt = K_N0;
          end
          DM_LO_HI: begin
            mul_a = MUL_W'(s1_r[31:0]); mul_b = MUL_W'(s1_r[S1_W-1:32]); kind_nxt = K_N33;
          end
          DM_HI_HI: begin
            mul_a = MUL_W'(s1_r[S1_W-1:32]); mul_b = MUL_W'(s1_r[S1_W-1:32]);
            kind_nxt = K_N64;
          end
          DM_M_M1: begin
            mul_a = MUL_W'(dev_m); mul_b = MUL_W'(dev_m - CNT_W'(1)); kind_nxt = K_MM;
          end
          DM_DRAIN: kind_nxt = K_NONE;
          default:  kind_nxt = K_NONE;
        endcase
      end
      S_DEV: begin
        div_start = 1'b1;
        div_dvd   = dacc_r;
        div_nb    = NB_W'(DVD_W);
        div_dvs   = mm_r;
      end
      S_SQRT: sqrt_start = 1'b1;
      S_VW: begin
        div_start = vol_r != '0;
        div_dvd   = DVD_W'(pv_r) << (DVD_W - PV_W);
        div_nb    = NB_W'(PV_W);
        div_dvs   = DVS_W'(vol_r);
      end
      S_OUT: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_NONE;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // accumulators and results
  assign ema_out = (span_r == '0 || fill_r == '0) ? '0 : ema_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r     <= '0;
      step_r    <= DM_M_S2LO;
      sma_sum_r <= '0;
      s1_r      <= '0;
      s2_r      <= '0;
      pv_r      <= '0;
      vol_r     <= '0;
      dacc_r    <= '0;
      sma_res_r <= '0;
      dev_res_r <= '0;
      vw_res_r  <= '0;
    end
    if (state_r == S_MX) begin
      if (sma_in) sma_sum_r <= sma_sum_r + S1_W'(x);
      if (dev_in) s1_r <= s1_r + S1_W'(x);
      vol_r <= vol_r + VS_W'(v);
    end
    if (state_r == S_ME) begin
      idx_r <= idx_r + CNT_W'(1);
      if (idx_r == '0) ema_r <= x;
    end
    if (state_r == S_DM) step_r <= dm_step_t'(step_r + 3'd1);
    if (state_r == S_ALPHA_W && div_done) alpha_r <= div_q[ALPHA_W-1:0];
    if (state_r == S_SMA_W && div_done) sma_res_r <= div_q[RES_W-1:0];
    if (state_r == S_DEV_W && div_done) dq_r <= div_q;
    if (state_r == S_SQRT_W && sqrt_done) dev_res_r <= sqrt_root;
    if (state_r == S_VW_W && div_done) begin
      vw_res_r <= (div_q > Q_W'({RES_W{1'b1}})) ? '1 : div_q[RES_W-1:0];
    end
    unique case (kind_r)
      K_SQ:    s2_r   <= s2_r + S2_W'(prod_r[63:0]);
      K_PV:    pv_r   <= pv_r + PV_W'(prod_r[63:0]);
      K_EMA:   ema_r  <= ema_r + prod_r[63:32];
      K_D0:    dacc_r <= dacc_r + DVD_W'(prod_r[66:0]);
      K_D32:   dacc_r <= dacc_r + (DVD_W'(prod_r[66:0]) << 32);
      K_D64:   dacc_r <= dacc_r + (DVD_W'(prod_r[66:0]) << 64);
      K_N0:    dacc_r <= dacc_r - DVD_W'(prod_r[66:0]);
      K_N33:   dacc_r <= dacc_r - (DVD_W'(prod_r[66:0]) << 33);
      K_N64:   dacc_r <= dacc_r - (DVD_W'(prod_r[66:0]) << 64);
      K_MM:    mm_r   <= prod_r[63:0];
      K_NONE:  ;
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {(OUT_DATA_W - 4 * RES_W - FILL_OUT_W)'(0), FILL_OUT_W'(fill_r),
                     vw_res_r, dev_res_r, ema_out, sma_res_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready) else $error("second request taken while busy");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(RING_DEPTH)) else $error("fill count beyond ring depth");
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_load) |=> out_tvalid) else $error("result not presented");

endmodule
`default_nettype wire

>>> sv/tws_ring.sv
// tick ring storage: one write port, one registered read port
// depends on tws_pkg
`timescale 1ns / 1ps
`default_nettype none
module tws_ring
  import tws_pkg::*;
#(
  parameter int DEPTH = DEF_RING_DEPTH,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [ENT_W-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [ENT_W-1:0] rdata
);

  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/tws_div.sv
// bit-serial restoring divider, one quotient bit per cycle, 64-bit saturated quotient
// depends on tws_pkg
`timescale 1ns / 1ps
`default_nettype none
module tws_div
  import tws_pkg::*;
#(
  parameter int DVD_W = 82,
  parameter int NB_W  = $clog2(DVD_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [NB_W-1:0]  nbits,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic      [Q_W-1:0]   quotient
);

  logic             busy_r, done_r, over_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] rem_r, dvs_r, rem_nxt;
  logic [Q_W-1:0]   q_r;
  logic [NB_W-1:0]  cnt_r;
  logic [DVS_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    qbit    = trial >= {1'b0, dvs_r};
    rem_nxt = qbit ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == NB_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      q_r    <= '0;
      over_r <= 1'b0;
      cnt_r  <= nbits;
    end else if (busy_r) begin
      dvd_r  <= dvd_r << 1;
      rem_r  <= rem_nxt;
      q_r    <= {q_r[Q_W-2:0], qbit};
      over_r <= over_r | q_r[Q_W-1];
      cnt_r  <= cnt_r - NB_W'(1);
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = over_r ? '1 : q_r;

endmodule
`default_nettype wire

>>> sv/tws_isqrt.sv
// bit-serial integer square root, two radicand bits per cycle
// depends on tws_pkg
`timescale 1ns / 1ps
`default_nettype none
module tws_isqrt
  import tws_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  radicand,
  output logic                   done,
  output logic      [ROOT_W-1:0] root
);

  localparam int CW = $clog2(ROOT_W + 1);

  logic              busy_r, done_r, ge;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+1:0] rem_r, rem_nxt;
  logic [ROOT_W+3:0] rem_t, trial;
  logic [ROOT_W-1:0] root_r;
  logic [CW-1:0]     cnt_r;

  always_comb begin
    rem_t   = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
    trial   = (ROOT_W + 4)'({root_r, 2'b01});
    ge      = rem_t >= trial;
    rem_nxt = ge ? (ROOT_W + 2)'(rem_t - trial) : rem_t[ROOT_W+1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CW'(ROOT_W);
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= {root_r[ROOT_W-2:0], ge};
      cnt_r  <= cnt_r - CW'(1);
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire
